FILE: rtl/core/cpt_pkg.sv
// package with item types and widths for the closest point on triangle block
`default_nettype none
package cpt_pkg;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned FracBits = 8;
  localparam int unsigned WgtBits = 24;
  localparam int unsigned DiffBits = CoordBits + 1;
  localparam int unsigned DotBits = 2 * DiffBits + 2;
  localparam int unsigned ProdBits = 2 * DotBits + 1;
  localparam int unsigned WideBits = ProdBits + 2;
  localparam int unsigned WgtW = WgtBits + 1;
  localparam int unsigned AccBits = CoordBits + WgtBits + 4;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
    logic signed [CoordBits-1:0] v0_x;
    logic signed [CoordBits-1:0] v0_y;
    logic signed [CoordBits-1:0] v0_z;
    logic signed [CoordBits-1:0] v1_x;
    logic signed [CoordBits-1:0] v1_y;
    logic signed [CoordBits-1:0] v1_z;
    logic signed [CoordBits-1:0] v2_x;
    logic signed [CoordBits-1:0] v2_y;
    logic signed [CoordBits-1:0] v2_z;
  } cpt_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] nearest_x;
    logic signed [CoordBits-1:0] nearest_y;
    logic signed [CoordBits-1:0] nearest_z;
    logic                        degenerate;
  } cpt_out_t;

  typedef enum logic [2:0] {
    SelZero,
    SelOne,
    SelDiv,
    SelOneMinusDiv
  } wsel_e;

  // one weight division request
  typedef struct packed {
    logic                       den_zero;
    logic                       clamp_zero;
    logic                       clamp_one;
    logic [WideBits-1:0]        num;
    logic [WideBits-1:0]        den;
  } div_req_t;
endpackage
`default_nettype wire

FILE: rtl/core/closest_point_on_triangle.sv
// top level: closest point on a triangle, fully pipelined
// throughput: one item per cycle, set by the per-bit divider stages
// busy is always low; the result strobe cannot be stalled
// reset clears all valid bits asynchronously, data registers are not reset
`default_nettype none
module closest_point_on_triangle (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cpt_pkg::cpt_in_t  in_i,
  output logic                   strobe_o,
  output cpt_pkg::cpt_out_t      out_o
);
  import cpt_pkg::*;

  localparam int unsigned W = WideBits;
  localparam int unsigned Half = DotBits / 2;
  localparam int unsigned HalfW = Half + 1;
  localparam int unsigned PpBits = 2 * Half + 2;

  typedef logic signed [DiffBits-1:0] df_t;
  typedef logic signed [W-1:0] wd_t;
  typedef logic signed [PpBits-1:0] pp_t;
  typedef struct packed {
    pp_t hh, hl, lh, ll;
  } ppq_t;

  assign busy = 1'b0;

  // stage 1: differences
  logic v1_q;
  df_t e0_q [3], e1_q [3], g_q [3];
  logic signed [CoordBits-1:0] q0_s1_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    e0_q[0] <= DiffBits'(in_i.v1_x) - DiffBits'(in_i.v0_x);
    e0_q[1] <= DiffBits'(in_i.v1_y) - DiffBits'(in_i.v0_y);
    e0_q[2] <= DiffBits'(in_i.v1_z) - DiffBits'(in_i.v0_z);
    e1_q[0] <= DiffBits'(in_i.v2_x) - DiffBits'(in_i.v0_x);
    e1_q[1] <= DiffBits'(in_i.v2_y) - DiffBits'(in_i.v0_y);
    e1_q[2] <= DiffBits'(in_i.v2_z) - DiffBits'(in_i.v0_z);
    g_q[0]  <= DiffBits'(in_i.v0_x) - DiffBits'(in_i.point_x);
    g_q[1]  <= DiffBits'(in_i.v0_y) - DiffBits'(in_i.point_y);
    g_q[2]  <= DiffBits'(in_i.v0_z) - DiffBits'(in_i.point_z);
    q0_s1_q[0] <= in_i.v0_x;
    q0_s1_q[1] <= in_i.v0_y;
    q0_s1_q[2] <= in_i.v0_z;
  end

  // stage 2: products of the dot terms
  logic v2_q;
  wd_t pa_q [3], pb_q [3], pc_q [3], pd_q [3], pe_q [3];
  df_t e0_2q [3], e1_2q [3];
  logic signed [CoordBits-1:0] q0_2q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  for (genvar i = 0; i < 3; i++) begin : g_p
    always_ff @(posedge clk_i) begin
      pa_q[i] <= W'(e0_q[i]) * W'(e0_q[i]);
      pb_q[i] <= W'(e0_q[i]) * W'(e1_q[i]);
      pc_q[i] <= W'(e1_q[i]) * W'(e1_q[i]);
      pd_q[i] <= W'(e0_q[i]) * W'(g_q[i]);
      pe_q[i] <= W'(e1_q[i]) * W'(g_q[i]);
      e0_2q[i] <= e0_q[i];
      e1_2q[i] <= e1_q[i];
      q0_2q[i] <= q0_s1_q[i];
    end
  end

  // stage 3: dot sums
  logic v3_q;
  wd_t a_q, b_q, c_q, d_q, e_q;
  df_t e0_3q [3], e1_3q [3];
  logic signed [CoordBits-1:0] q0_3q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    a_q <= pa_q[0] + pa_q[1] + pa_q[2];
    b_q <= pb_q[0] + pb_q[1] + pb_q[2];
    c_q <= pc_q[0] + pc_q[1] + pc_q[2];
    d_q <= pd_q[0] + pd_q[1] + pd_q[2];
    e_q <= pe_q[0] + pe_q[1] + pe_q[2];
    e0_3q <= e0_2q;
    e1_3q <= e1_2q;
    q0_3q <= q0_2q;
  end

  // dot terms fit in DotBits signed; split into a signed high and unsigned low half
  function automatic ppq_t split_mul(input wd_t x, input wd_t y);
    logic signed [HalfW-1:0] xh, xl, yh, yl;
    ppq_t r;
    xh = HalfW'($signed(x[DotBits-1:Half]));
    xl = {1'b0, x[Half-1:0]};
    yh = HalfW'($signed(y[DotBits-1:Half]));
    yl = {1'b0, y[Half-1:0]};
    r.hh = PpBits'(xh) * PpBits'(yh);
    r.hl = PpBits'(xh) * PpBits'(yl);
    r.lh = PpBits'(xl) * PpBits'(yh);
    r.ll = PpBits'(xl) * PpBits'(yl);
    return r;
  endfunction

  function automatic wd_t join_pp(input ppq_t p);
    return (W'(p.hh) <<< (2 * Half)) + ((W'(p.hl) + W'(p.lh)) <<< Half) + W'(p.ll);
  endfunction

  // stage 4: second-order products
  logic v4_q;
  ppq_t ac_q, bb_q, be_q, cd_q, bd_q, ae_q;
  wd_t a4_q, b4_q, c4_q, d4_q, e4_q;
  df_t e0_4q [3], e1_4q [3];
  logic signed [CoordBits-1:0] q0_4q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    ac_q <= split_mul(a_q, c_q);
    bb_q <= split_mul(b_q, b_q);
    be_q <= split_mul(b_q, e_q);
    cd_q <= split_mul(c_q, d_q);
    bd_q <= split_mul(b_q, d_q);
    ae_q <= split_mul(a_q, e_q);
    a4_q <= a_q; b4_q <= b_q; c4_q <= c_q; d4_q <= d_q; e4_q <= e_q;
    e0_4q <= e0_3q; e1_4q <= e1_3q; q0_4q <= q0_3q;
  end

  // stage 5: det, s, t and edge terms
  logic v5_q;
  wd_t det_q, s_q, t_q, den12_q, a5_q, c5_q, d5_q, e5_q, t0a_q, t1a_q, t0b_q, t1b_q;
  df_t e0_5q [3], e1_5q [3];
  logic signed [CoordBits-1:0] q0_5q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    det_q   <= join_pp(ac_q) - join_pp(bb_q);
    s_q     <= join_pp(be_q) - join_pp(cd_q);
    t_q     <= join_pp(bd_q) - join_pp(ae_q);
    den12_q <= a4_q - b4_q - b4_q + c4_q;
    t0a_q   <= b4_q + d4_q;
    t1a_q   <= c4_q + e4_q;
    t0b_q   <= b4_q + e4_q;
    t1b_q   <= a4_q + d4_q;
    a5_q <= a4_q; c5_q <= c4_q; d5_q <= d4_q; e5_q <= e4_q;
    e0_5q <= e0_4q; e1_5q <= e1_4q; q0_5q <= q0_4q;
  end

  // stage 6: region decision and divider operands
  logic v6_q;
  div_req_t rs_q, rt_q;
  wsel_e sels_q, selt_q;
  df_t e0_6q [3], e1_6q [3];
  logic signed [CoordBits-1:0] q0_6q [3];
  div_req_t rs_d, rt_d;
  wsel_e sels_d, selt_d;

  function automatic div_req_t mk_req(input wd_t num, input wd_t den);
    div_req_t r;
    r.num = num;
    r.den = den;
    r.den_zero = (den == '0);
    r.clamp_zero = (num <= 0);
    r.clamp_one = (num >= den);
    return r;
  endfunction

  always_comb begin
    wd_t sum, n1, n2, n3;
    sum = s_q + t_q;
    n1 = t1a_q - t0a_q;
    n2 = t1b_q - t0b_q;
    n3 = n1;
    rs_d = '0; rt_d = '0;
    rs_d.den = W'(1); rt_d.den = W'(1);
    sels_d = SelZero; selt_d = SelZero;
    if (!(sum > det_q)) begin
      if (s_q < 0) begin
        if (t_q < 0 && d5_q < 0) begin
          rs_d = mk_req(-d5_q, a5_q); sels_d = SelDiv;
        end else begin
          rt_d = mk_req(-e5_q, c5_q); selt_d = SelDiv;
        end
      end else if (t_q < 0) begin
        rs_d = mk_req(-d5_q, a5_q); sels_d = SelDiv;
      end else begin
        rs_d = mk_req(s_q, det_q); sels_d = SelDiv;
        rt_d = mk_req(t_q, det_q); selt_d = SelDiv;
      end
    end else begin
      if (s_q < 0) begin
        if (t1a_q > t0a_q) begin
          rs_d = mk_req(n1, den12_q); sels_d = SelDiv; selt_d = SelOneMinusDiv;
        end else begin
          rt_d = mk_req(-e5_q, c5_q); selt_d = SelDiv;
        end
      end else if (t_q < 0) begin
        if (t1b_q > t0b_q) begin
          rt_d = mk_req(n2, den12_q); selt_d = SelDiv; sels_d = SelOneMinusDiv;
        end else begin
          rs_d = mk_req(-d5_q, a5_q); sels_d = SelDiv;
        end
      end else begin
        if (n3 <= 0) begin
          sels_d = SelZero; selt_d = SelOne;
        end else begin
          rs_d = mk_req(n3, den12_q); sels_d = SelDiv; selt_d = SelOneMinusDiv;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    rs_q <= rs_d; rt_q <= rt_d; sels_q <= sels_d; selt_q <= selt_d;
    e0_6q <= e0_5q; e1_6q <= e1_5q; q0_6q <= q0_5q;
  end

  // dividers, numerator below denominator when used
  logic [WgtBits-1:0] qs, qt;
  logic vd, vdt;
  cpt_divider #(.Bits(WgtBits), .NBits(W)) u_div_s (
    .clk_i, .rst_ni, .valid_i(v6_q), .num_i(rs_q.num), .den_i(rs_q.den),
    .quot_o(qs), .valid_o(vd)
  );
  cpt_divider #(.Bits(WgtBits), .NBits(W)) u_div_t (
    .clk_i, .rst_ni, .valid_i(v6_q), .num_i(rt_q.num), .den_i(rt_q.den),
    .quot_o(qt), .valid_o(vdt)
  );

  // side data delay line matching the divider
  typedef struct packed {
    logic dzs, czs, cos, dzt, czt, cot;
    wsel_e sels, selt;
    logic [2:0][DiffBits-1:0] e0, e1;
    logic [2:0][CoordBits-1:0] q0;
  } side_t;
  side_t sd_q [WgtBits+1];
  always_comb begin
    sd_q[0].dzs = rs_q.den_zero; sd_q[0].czs = rs_q.clamp_zero; sd_q[0].cos = rs_q.clamp_one;
    sd_q[0].dzt = rt_q.den_zero; sd_q[0].czt = rt_q.clamp_zero; sd_q[0].cot = rt_q.clamp_one;
    sd_q[0].sels = sels_q; sd_q[0].selt = selt_q;
    for (int i = 0; i < 3; i++) begin
      sd_q[0].e0[i] = e0_6q[i];
      sd_q[0].e1[i] = e1_6q[i];
      sd_q[0].q0[i] = q0_6q[i];
    end
  end
  for (genvar k = 0; k < WgtBits; k++) begin : g_side
    always_ff @(posedge clk_i) sd_q[k+1] <= sd_q[k];
  end

  // weight resolve
  logic [WgtW-1:0] ws_d, wt_d, ws_q, wt_q, dvs, dvt;
  logic deg_d, deg_q, v7_q;
  side_t sx;
  always_comb begin
    sx = sd_q[WgtBits];
    deg_d = 1'b0;
    if (sx.dzs && sx.sels == SelDiv) begin dvs = '0; deg_d = 1'b1; end
    else if (sx.czs) dvs = '0;
    else if (sx.cos) dvs = WgtW'(1) << WgtBits;
    else dvs = {1'b0, qs};
    if (sx.dzt && sx.selt == SelDiv) begin dvt = '0; deg_d = 1'b1; end
    else if (sx.czt) dvt = '0;
    else if (sx.cot) dvt = WgtW'(1) << WgtBits;
    else dvt = {1'b0, qt};
    unique case (sx.sels)
      SelZero: ws_d = '0;
      SelOne: ws_d = WgtW'(1) << WgtBits;
      SelDiv: ws_d = dvs;
      SelOneMinusDiv: ws_d = (WgtW'(1) << WgtBits) - dvt;
      default: ws_d = '0;
    endcase
    unique case (sx.selt)
      SelZero: wt_d = '0;
      SelOne: wt_d = WgtW'(1) << WgtBits;
      SelDiv: wt_d = dvt;
      SelOneMinusDiv: wt_d = (WgtW'(1) << WgtBits) - dvs;
      default: wt_d = '0;
    endcase
  end
  side_t s7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else v7_q <= vd;
  end
  always_ff @(posedge clk_i) begin
    ws_q <= ws_d; wt_q <= wt_d; deg_q <= deg_d; s7_q <= sx;
  end

  // stage 8: weighted edge products
  typedef logic signed [AccBits-1:0] acc_t;
  acc_t ps_q [3], pt_q [3], pq_q [3];
  logic v8_q, deg8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else v8_q <= v7_q;
  end
  for (genvar i = 0; i < 3; i++) begin : g_m
    always_ff @(posedge clk_i) begin
      ps_q[i] <= AccBits'($signed({1'b0, ws_q})) * AccBits'($signed(s7_q.e0[i]));
      pt_q[i] <= AccBits'($signed({1'b0, wt_q})) * AccBits'($signed(s7_q.e1[i]));
      pq_q[i] <= AccBits'($signed(s7_q.q0[i])) <<< WgtBits;
    end
  end
  always_ff @(posedge clk_i) deg8_q <= deg_q;

  // stage 9: sum, floor shift, saturate
  cpt_out_t res_d, res_q;
  logic v9_q;
  always_comb begin
    acc_t sm, sh;
    logic signed [CoordBits-1:0] r [3];
    for (int i = 0; i < 3; i++) begin
      sm = pq_q[i] + ps_q[i] + pt_q[i];
      sh = sm >>> WgtBits;
      if (sh > acc_t'({1'b0, {(CoordBits-1){1'b1}}})) r[i] = {1'b0, {(CoordBits-1){1'b1}}};
      else if (sh < -acc_t'({1'b0, 1'b1, {(CoordBits-1){1'b0}}}))
        r[i] = {1'b1, {(CoordBits-1){1'b0}}};
      else r[i] = sh[CoordBits-1:0];
    end
    res_d.nearest_x = r[0];
    res_d.nearest_y = r[1];
    res_d.nearest_z = r[2];
    res_d.degenerate = deg8_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) res_q <= res_d;

  assign strobe_o = v9_q;
  assign out_o = res_q;

  a_busy_low: assert property (@(posedge clk_i) busy == 1'b0)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni) v6_q |=> ##23 vd)
    else $error("divider valid lost");
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni) vd == vdt)
    else $error("dividers out of step");
  a_wsum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && s7_q.sels == SelOneMinusDiv) |-> (ws_q + wt_q == (WgtW'(1) << WgtBits)))
    else $error("complement weights do not sum to one");
endmodule
`default_nettype wire

FILE: rtl/core/cpt_divider.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module cpt_divider #(
  parameter int unsigned Bits = 24,
  parameter int unsigned NBits = 100
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [NBits-1:0] num_i,
  input  wire logic [NBits-1:0] den_i,
  output logic      [Bits-1:0]  quot_o,
  output logic                  valid_o
);
  logic [NBits:0]   rem_q [Bits+1];
  logic [NBits-1:0] den_q [Bits+1];
  logic [Bits-1:0]  quo_q [Bits+1];
  logic [Bits:0]    vld_q;

  always_comb begin
    rem_q[0] = {1'b0, num_i};
    den_q[0] = den_i;
    quo_q[0] = '0;
    vld_q[0] = valid_i;
  end

  for (genvar k = 0; k < Bits; k++) begin : g_stage
    logic [NBits+1:0] sh;
    logic [NBits+1:0] df;
    always_comb begin
      sh = {rem_q[k], 1'b0};
      df = sh - {2'b00, den_q[k]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      den_q[k+1] <= den_q[k];
      if (!df[NBits+1]) begin
        rem_q[k+1] <= df[NBits:0];
        quo_q[k+1] <= {quo_q[k][Bits-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= sh[NBits:0];
        quo_q[k+1] <= {quo_q[k][Bits-2:0], 1'b0};
      end
    end
  end

  assign quot_o  = quo_q[Bits];
  assign valid_o = vld_q[Bits];
endmodule
`default_nettype wire

FILE: bench/cpt_checker.sv
// checker for the closest point on triangle block: predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none
module cpt_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire cpt_pkg::cpt_in_t  in_i,
  input  wire logic              strobe_o,
  input  wire cpt_pkg::cpt_out_t out_o,
  output int                     fail_count,
  output int                     pending_count
);
  import cpt_pkg::*;

  typedef logic signed [191:0] wide_t;

  cpt_out_t nearest_q[$];

  function automatic logic signed [63:0] split_weight(wide_t num, wide_t den, ref logic deg);
    wide_t rem;
    logic signed [63:0] q;
    q = 0;
    if (den == 0) begin
      deg = 1'b1;
      return 0;
    end
    if (num <= 0) return 0;
    if (num >= den) return 64'sd1 <<< WgtBits;
    rem = num;
    for (int i = 0; i < WgtBits; i++) begin
      rem = rem <<< 1;
      q = q * 2;
      if (rem >= den) begin
        rem = rem - den;
        q = q + 1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [CoordBits-1:0] round_down_sat(wide_t acc);
    wide_t q;
    q = acc >>> WgtBits;
    if (q > wide_t'(8388607)) q = wide_t'(8388607);
    if (q < -wide_t'(8388608)) q = -wide_t'(8388608);
    return q[CoordBits-1:0];
  endfunction

  function automatic cpt_out_t nearest_point(cpt_in_t it);
    wide_t p[3], q0[3], e0[3], e1[3], g[3];
    wide_t aa, bb, cc, dd, ee, det, s, t, t0, t1, n, den12, one;
    logic signed [63:0] ws, wt;
    logic deg;
    cpt_out_t r;
    deg = 1'b0;
    one = wide_t'(1) <<< WgtBits;
    p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z;
    q0[0] = it.v0_x; q0[1] = it.v0_y; q0[2] = it.v0_z;
    e0[0] = wide_t'(it.v1_x) - q0[0]; e0[1] = wide_t'(it.v1_y) - q0[1];
    e0[2] = wide_t'(it.v1_z) - q0[2];
    e1[0] = wide_t'(it.v2_x) - q0[0]; e1[1] = wide_t'(it.v2_y) - q0[1];
    e1[2] = wide_t'(it.v2_z) - q0[2];
    for (int i = 0; i < 3; i++) g[i] = q0[i] - p[i];
    aa = 0; bb = 0; cc = 0; dd = 0; ee = 0;
    for (int i = 0; i < 3; i++) begin
      aa += e0[i] * e0[i];
      bb += e0[i] * e1[i];
      cc += e1[i] * e1[i];
      dd += e0[i] * g[i];
      ee += e1[i] * g[i];
    end
    det = aa * cc - bb * bb;
    s = bb * ee - cc * dd;
    t = bb * dd - aa * ee;
    den12 = aa - bb - bb + cc;
    if (s + t <= det) begin
      if (s < 0) begin
        if (t < 0 && dd < 0) begin
          ws = split_weight(-dd, aa, deg); wt = 0;
        end else begin
          ws = 0; wt = split_weight(-ee, cc, deg);
        end
      end else if (t < 0) begin
        ws = split_weight(-dd, aa, deg); wt = 0;
      end else begin
        ws = split_weight(s, det, deg);
        wt = split_weight(t, det, deg);
      end
    end else begin
      if (s < 0) begin
        t0 = bb + dd; t1 = cc + ee;
        if (t1 > t0) begin
          ws = split_weight(t1 - t0, den12, deg); wt = 64'(one - ws);
        end else begin
          ws = 0; wt = split_weight(-ee, cc, deg);
        end
      end else if (t < 0) begin
        t0 = bb + ee; t1 = aa + dd;
        if (t1 > t0) begin
          wt = split_weight(t1 - t0, den12, deg); ws = 64'(one - wt);
        end else begin
          wt = 0; ws = split_weight(-dd, aa, deg);
        end
      end else begin
        n = cc + ee - bb - dd;
        if (n <= 0) ws = 0;
        else ws = split_weight(n, den12, deg);
        wt = 64'(one - ws);
      end
    end
    r.nearest_x = round_down_sat(q0[0] * one + ws * e0[0] + wt * e1[0]);
    r.nearest_y = round_down_sat(q0[1] * one + ws * e0[1] + wt * e1[1]);
    r.nearest_z = round_down_sat(q0[2] * one + ws * e0[2] + wt * e1[2]);
    r.degenerate = deg;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_count = nearest_q.size();

  always @(posedge clk_i) begin
    cpt_out_t exp_r;
    if (rst_ni) begin
      if (start && !busy) nearest_q.push_back(nearest_point(in_i));
      if (strobe_o) begin
        if (nearest_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          exp_r = nearest_q.pop_front();
          if (out_o.nearest_x !== exp_r.nearest_x)
            report_mismatch("nearest_x", out_o.nearest_x, exp_r.nearest_x);
          if (out_o.nearest_y !== exp_r.nearest_y)
            report_mismatch("nearest_y", out_o.nearest_y, exp_r.nearest_y);
          if (out_o.nearest_z !== exp_r.nearest_z)
            report_mismatch("nearest_z", out_o.nearest_z, exp_r.nearest_z);
          if (out_o.degenerate !== exp_r.degenerate)
            report_mismatch("degenerate", out_o.degenerate, exp_r.degenerate);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// testbench top for the closest point on triangle block: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import cpt_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int Latency = 33;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cpt_in_t in_i = '0;
  logic strobe_o;
  cpt_out_t out_o;
  int fail_count, pending_count;
  int cycle_count = 0;

  closest_point_on_triangle u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .strobe_o(strobe_o), .out_o(out_o)
  );

  cpt_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .strobe_o(strobe_o), .out_o(out_o), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 2047)) - 1024);
      2: return 24'($signed($urandom_range(0, 63)) - 32);
      default: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  function automatic cpt_in_t rand_query();
    cpt_in_t it;
    int mode;
    logic [24*12-1:0] flat;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    for (int i = 0; i < 12; i++) flat[i*24 +: 24] = rand_coord(mode);
    it = flat;
    case ($urandom_range(0, 9))
      0: begin it.v1_x = it.v0_x; it.v1_y = it.v0_y; it.v1_z = it.v0_z; end
      1: begin it.v2_x = it.v1_x; it.v2_y = it.v1_y; it.v2_z = it.v1_z; end
      2: begin
        it.v2_x = 24'(it.v0_x + 2 * (it.v1_x - it.v0_x));
        it.v2_y = 24'(it.v0_y + 2 * (it.v1_y - it.v0_y));
        it.v2_z = 24'(it.v0_z + 2 * (it.v1_z - it.v0_z));
      end
      3: begin it.point_x = it.v0_x; it.point_y = it.v0_y; it.point_z = it.v0_z; end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_query(cpt_in_t it);
    start <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    cpt_in_t it;
    int burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    it = '0;
    send_query(it);
    it = '1;
    send_query(it);
    it = {12{24'h7fffff}};
    send_query(it);
    it = {12{24'h800000}};
    send_query(it);
    it = {24'h800000, 24'h800000, 24'h800000, {9{24'h7fffff}}};
    send_query(it);
    it = {24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000,
          24'h7fffff, 24'h800000, 24'h000000, 24'h800000, 24'h7fffff, 24'h7fffff};
    send_query(it);
    // unit triangle, query in each region
    for (int k = 0; k < 9; k++) begin
      it = '0;
      it.v1_x = 24'd256; it.v2_y = 24'd256;
      it.point_x = 24'($signed((k % 3) * 256 - 128));
      it.point_y = 24'($signed((k / 3) * 256 - 128));
      it.point_z = 24'd77;
      send_query(it);
    end
    // coincident and collinear vertices
    it = '0; it.point_x = 24'd5;
    send_query(it);
    it = '0; it.v1_x = 24'd100; it.v2_x = 24'd200; it.point_y = 24'd50;
    send_query(it);
    it = '0; it.v1_x = 24'd100; it.v2_x = 24'd100; it.point_x = 24'd300;
    send_query(it);

    // let the pipeline drain fully
    idle_cycles(1);
    while (pending_count != 0) @(posedge clk_i);

    for (int n = 0; n < 1800; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        send_query(rand_query());
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    idle_cycles(1);
    while (pending_count != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: closest_point_on_triangle.f
rtl/core/cpt_pkg.sv
rtl/core/cpt_divider.sv
rtl/core/closest_point_on_triangle.sv
bench/cpt_checker.sv
bench/tb_top.sv
